/* design/assert_macros.svh */
// Assertion macros shared by the router RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every clock, masked while reset is asserted
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check on every clock, including reset cycles
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* design/slpr_pkg.sv */
// Package for the shared load port router: payload types, owner and response codes.
// No dependencies; used by the channel interfaces and the router top level.
`timescale 1ns / 1ps

package slpr_pkg;

  // Parameter defaults
  localparam int ID_BITS_DEF        = 8;
  localparam int ROUTE_ID_BASE_DEF  = 128;
  localparam int ROUTE_ID_COUNT_DEF = 16;
  localparam int ADDR_BITS_DEF      = 32;

  localparam int NUM_CLIENTS = 4;

  typedef logic [2:0] owner_t;
  localparam owner_t OWN_NONE  = 3'd0;
  localparam owner_t OWN_FETCH = 3'd1;
  localparam owner_t OWN_WALK  = 3'd2;
  localparam owner_t OWN_DTLB  = 3'd3;
  localparam owner_t OWN_ITLB  = 3'd4;

  typedef logic [2:0] wake_t;
  localparam wake_t WK_NONE = 3'b000;
  localparam wake_t WK_DTLB = 3'b001;
  localparam wake_t WK_ITLB = 3'b010;
  localparam wake_t WK_WALK = 3'b100;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HIT      = 2'd0;
  localparam kind_t KIND_CONFLICT = 2'd1;

  typedef logic [1:0] fetch_res_t;
  localparam fetch_res_t FR_NONE = 2'd0;
  localparam fetch_res_t FR_HIT  = 2'd1;
  localparam fetch_res_t FR_MISS = 2'd2;

  typedef struct packed {
    logic [3:0]  request_mask;
    logic [31:0] fetch_addr;
    logic [31:0] walk_addr;
    logic [31:0] dtlb_addr;
    logic [31:0] itlb_addr;
    logic        lsu_port_valid;
    logic [7:0]  lsu_port_id;
    logic        resp_vld;
    logic [7:0]  resp_id;
    kind_t       resp_kind;
    logic [31:0] resp_word;
    logic        fill_done;
  } slpr_in_t;

  typedef struct packed {
    owner_t      port_owner;
    logic [31:0] port_addr;
    logic [7:0]  port_id;
    fetch_res_t  fetch_result;
    logic [31:0] result_word;
    owner_t      event_owner;
    logic [31:0] event_addr;
    logic [7:0]  event_id;
    wake_t       wake_mask;
    logic        lsu_replay_vld;
    logic [7:0]  lsu_replay_id;
  } slpr_out_t;

  // Wakeup bit that belongs to a walker-type owner; fetch has none
  function automatic wake_t owner_wake_bit(owner_t owner);
    wake_t w;
    w = WK_NONE;
    case (owner)
      OWN_DTLB: w = WK_DTLB;
      OWN_ITLB: w = WK_ITLB;
      OWN_WALK: w = WK_WALK;
      default:  w = WK_NONE;
    endcase
    return w;
  endfunction

endpackage

/* design/slpr_in_if.sv */
// Input channel of the shared load port router: valid/ready plus the port traffic payload.
// Depends on slpr_pkg for the payload type.
`timescale 1ns / 1ps

interface slpr_in_if import slpr_pkg::*; ;
  logic     valid;
  logic     ready;
  slpr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/slpr_out_if.sv */
// Result channel of the shared load port router: valid/ready plus grant and response report.
// Depends on slpr_pkg for the payload type.
`timescale 1ns / 1ps

interface slpr_out_if import slpr_pkg::*; ;
  logic      valid;
  logic      ready;
  slpr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/shared_load_port_router.sv */
// Shared load port router top level.
// Depends on slpr_pkg, slpr_in_if, slpr_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Four clients (fetch, page walker, dtlb refill, itlb refill) share one data
// cache load port. Each input transaction on in_ch carries its port traffic:
// the request bits and addresses, the lsu claim on the port, and the
// cache response with the fill flag. Each one yields exactly one result
// transaction on out_ch: the grant with its route id, the fetch result, the
// walker hit event, walker wakeups and the lsu conflict replay.
// The response is checked against the load granted by the previous
// transaction; the grant uses fixed priority and skips that previous owner.
// The result is registered: it appears in the cycle after the input is accepted.
// Throughput: one transaction per cycle while out_ch is ready; the whole step is
// short combinational logic between the router state and the output register.
// While the receiver stalls, the output register holds and in_ch.ready drops
// once it is full; a new transaction is taken in the same cycle the held
// result is taken. Reset clears the issued load, the saved lsu claim and the
// wait mask, and loads the route id counter with its base value.
module shared_load_port_router
  import slpr_pkg::*;
#(
  parameter int ID_BITS        = ID_BITS_DEF,
  parameter int ROUTE_ID_BASE  = ROUTE_ID_BASE_DEF,
  parameter int ROUTE_ID_COUNT = ROUTE_ID_COUNT_DEF,
  parameter int ADDR_BITS      = ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slpr_in_if.sink    in_ch,
  slpr_out_if.source out_ch
);

  // Stored address width: the port carries 32 bits at most
  localparam int AW       = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int ID_LAST  = ROUTE_ID_BASE + ROUTE_ID_COUNT - 1;
  localparam int CW       = 18;

  // Router state
  owner_t               issued_owner_r;
  logic [AW-1:0]        issued_addr_r;
  logic [ID_BITS-1:0]   issued_id_r;
  logic [ID_BITS-1:0]   next_id_r;
  logic                 saved_lsu_valid_r;
  logic [7:0]           saved_lsu_id_r;
  wake_t                wait_mask_r;

  // Output register
  logic                 out_valid_r;
  slpr_out_t            out_data_r;

  logic                 in_fire;
  slpr_in_t             in_d;
  logic [31:0]          addrs [NUM_CLIENTS];
  owner_t               grant;
  logic [AW-1:0]        gaddr;
  logic                 match;
  wake_t                wait_nxt;
  logic [ID_BITS-1:0]   next_id_nxt;
  logic [CW-1:0]        id_ext;
  slpr_out_t            res;

  assign in_d     = in_ch.data;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign addrs[0] = in_d.fetch_addr;
  assign addrs[1] = in_d.walk_addr;
  assign addrs[2] = in_d.dtlb_addr;
  assign addrs[3] = in_d.itlb_addr;

  // Advance the route id inside its rotating range
  always_comb begin
    id_ext = CW'(next_id_r);
    if (id_ext < CW'(ROUTE_ID_BASE) || id_ext >= CW'(ID_LAST)) begin
      next_id_nxt = ID_BITS'(ROUTE_ID_BASE);
    end else begin
      next_id_nxt = ID_BITS'(id_ext + CW'(1));
    end
  end

  // Grant by fixed priority, skipping the owner issued by the previous transaction
  always_comb begin
    grant = OWN_NONE;
    gaddr = '0;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      if (grant == OWN_NONE && in_d.request_mask[i] &&
          issued_owner_r != owner_t'(i + 1)) begin
        grant = owner_t'(i + 1);
        gaddr = addrs[i][AW-1:0];
      end
    end
  end

  // Response phase against the previously issued load
  assign match = (issued_owner_r != OWN_NONE) && in_d.resp_vld &&
                 (in_d.resp_id == 8'(issued_id_r));

  always_comb begin
    res              = '0;
    wait_nxt         = wait_mask_r;
    res.port_owner   = grant;
    res.port_addr    = 32'(gaddr);
    res.port_id      = (grant != OWN_NONE) ? 8'(next_id_r) : 8'd0;
    if (match) begin
      res.lsu_replay_vld = saved_lsu_valid_r;
      res.lsu_replay_id  = saved_lsu_id_r;
      case (in_d.resp_kind)
        KIND_HIT: begin
          res.result_word = in_d.resp_word;
          if (issued_owner_r == OWN_FETCH) begin
            res.fetch_result = FR_HIT;
          end else begin
            res.event_owner = issued_owner_r;
            res.event_addr  = 32'(issued_addr_r);
            res.event_id    = 8'(issued_id_r);
          end
        end
        KIND_CONFLICT: begin
          if (issued_owner_r == OWN_FETCH) res.fetch_result = FR_MISS;
          res.wake_mask = owner_wake_bit(issued_owner_r);
        end
        default: begin
          // Miss: park the owner unless the fill lands this cycle
          if (issued_owner_r == OWN_FETCH) res.fetch_result = FR_MISS;
          if (in_d.fill_done) begin
            res.wake_mask = owner_wake_bit(issued_owner_r);
          end else begin
            wait_nxt = owner_wake_bit(issued_owner_r);
          end
        end
      endcase
    end
    // A fill releases every parked walker
    if (in_d.fill_done) begin
      res.wake_mask = res.wake_mask | wait_nxt;
      wait_nxt      = WK_NONE;
    end
  end

  // Update router state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_owner_r    <= OWN_NONE;
      issued_addr_r     <= '0;
      issued_id_r       <= '0;
      next_id_r         <= ID_BITS'(ROUTE_ID_BASE);
      saved_lsu_valid_r <= 1'b0;
      saved_lsu_id_r    <= '0;
      wait_mask_r       <= WK_NONE;
    end else if (in_fire) begin
      issued_owner_r <= grant;
      issued_addr_r  <= gaddr;
      issued_id_r    <= next_id_r;
      wait_mask_r    <= wait_nxt;
      if (grant != OWN_NONE) begin
        saved_lsu_valid_r <= in_d.lsu_port_valid;
        saved_lsu_id_r    <= in_d.lsu_port_id;
        next_id_r         <= next_id_nxt;
      end
    end
  end

  // Hold the result until taken; refill in the same cycle it leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Checks
  `ASSERT_CLK(a_wait_single, $onehot0(wait_mask_r))
  `ASSERT_CLK(a_event_not_fetch,
    out_valid_r && out_data_r.event_owner != OWN_NONE |-> out_data_r.fetch_result == FR_NONE)
  `ASSERT_CLK(a_id_only_on_grant,
    out_valid_r && out_data_r.port_owner == OWN_NONE |-> out_data_r.port_id == 8'd0)
  `ASSERT_CLK(a_no_self_regrant,
    in_fire && grant != OWN_NONE |=> issued_owner_r != $past(issued_owner_r))

endmodule
